[rtl/bmd_pkg.sv]
// Shared types, constants and decode functions for the BLE-MIDI to USB-MIDI decoder.
package bmd_pkg;

  localparam int unsigned EventCountBits = 12;
  localparam int unsigned MaxResults     = 4;
  localparam int unsigned MaxPlanned     = 3;

  localparam logic [7:0] HeaderMask        = 8'hC0;
  localparam logic [7:0] HeaderValue       = 8'h80;
  localparam logic [7:0] StatusSysexStart  = 8'hF0;
  localparam logic [7:0] StatusTimeCode    = 8'hF1;
  localparam logic [7:0] StatusSongPos     = 8'hF2;
  localparam logic [7:0] StatusSongSelect  = 8'hF3;
  localparam logic [7:0] StatusTuneRequest = 8'hF6;
  localparam logic [7:0] StatusSysexEnd    = 8'hF7;
  localparam logic [7:0] StatusRealtimeMin = 8'hF8;
  localparam logic [3:0] StatusSystemNib   = 4'hF;

  localparam logic [3:0] CinNone            = 4'h0;
  localparam logic [3:0] CinTwoByteCommon   = 4'h2;
  localparam logic [3:0] CinThreeByteCommon = 4'h3;
  localparam logic [3:0] CinSysexCont       = 4'h4;
  localparam logic [3:0] CinSysexEnd1       = 4'h5;
  localparam logic [3:0] CinSingleCommon    = 4'h5;
  localparam logic [3:0] CinSysexEnd2       = 4'h6;
  localparam logic [3:0] CinSysexEnd3       = 4'h7;
  localparam logic [3:0] CinProgramChange   = 4'hC;
  localparam logic [3:0] CinChannelPressure = 4'hD;
  localparam logic [3:0] CinSingleByte      = 4'hF;

  typedef enum logic [1:0] {
    KindEvent  = 2'd0,
    KindAccept = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhTop     = 2'd1,
    PhStamped = 2'd2,
    PhData    = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e                     kind;
    logic [3:0]                cin;
    logic [7:0]                first;
    logic [7:0]                second;
    logic [7:0]                third;
    logic [EventCountBits-1:0] count;
  } result_t;

  typedef struct packed {
    phase_e                    phase;
    logic                      sysex_on;
    logic [2:0][7:0]           chunk;
    logic [1:0]                fill;
    logic [7:0]                run_status;
    logic                      stamp_needed;
    logic [1:0][7:0]           msg;
    logic [1:0]                data_left;
    logic [EventCountBits-1:0] events;
    logic                      failed;
  } state_t;

  typedef struct packed {
    logic [1:0] len;
    logic [3:0] cin;
  } msg_info_t;

  localparam state_t StateReset = '{
    phase:        PhHeader,
    sysex_on:     1'b0,
    chunk:        '0,
    fill:         2'd0,
    run_status:   8'd0,
    stamp_needed: 1'b1,
    msg:          '0,
    data_left:    2'd0,
    events:       '0,
    failed:       1'b0
  };

  function automatic msg_info_t msg_info(logic [7:0] s);
    msg_info_t r;
    r.len = 2'd0;
    r.cin = CinNone;
    if (s[7:4] != StatusSystemNib) begin
      r.cin = s[7:4];
      r.len = (s[7:4] == CinProgramChange || s[7:4] == CinChannelPressure) ? 2'd2 : 2'd3;
    end else if (s >= StatusRealtimeMin) begin
      r.cin = CinSingleByte;
      r.len = 2'd1;
    end else begin
      unique case (s)
        StatusTimeCode, StatusSongSelect: begin
          r.cin = CinTwoByteCommon;
          r.len = 2'd2;
        end
        StatusSongPos: begin
          r.cin = CinThreeByteCommon;
          r.len = 2'd3;
        end
        StatusTuneRequest: begin
          r.cin = CinSingleCommon;
          r.len = 2'd1;
        end
        default: begin
          r.cin = CinNone;
          r.len = 2'd0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic result_t mk_event(logic [3:0] cin, logic [7:0] a, logic [7:0] b,
                                       logic [7:0] c);
    result_t r;
    r.kind   = KindEvent;
    r.cin    = cin;
    r.first  = a;
    r.second = b;
    r.third  = c;
    r.count  = '0;
    return r;
  endfunction

endpackage

[rtl/bmd_in_if.sv]
// Byte channel into the decoder: valid/ready with one packet byte per word.
interface bmd_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_packet;

  modport source (output valid, output data_byte, output last_of_packet, input ready);
  modport sink (input valid, input data_byte, input last_of_packet, output ready);
endinterface

[rtl/bmd_out_if.sv]
// Result channel out of the decoder: valid/ready with one event or packet verdict per word.
interface bmd_out_if import bmd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [3:0]                code_index;
  logic [7:0]                midi_first;
  logic [7:0]                midi_second;
  logic [7:0]                midi_third;
  logic [EventCountBits-1:0] event_count;
  logic                      last;

  modport source (
    output valid, output kind, output code_index, output midi_first, output midi_second,
    output midi_third, output event_count, output last, input ready
  );
  modport sink (
    input valid, input kind, input code_index, input midi_first, input midi_second,
    input midi_third, input event_count, input last, output ready
  );
endinterface

[rtl/bmd_parse.sv]
// Single-pass step logic: next parser state and the results caused by one packet byte.
module bmd_parse import bmd_pkg::*; (
  input  state_t                           state_i,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_of_packet_i,
  input  logic [EventCountBits-1:0]        max_events_i,
  output state_t                           state_o,
  output result_t [MaxResults-1:0]         res_o,
  output logic [$clog2(MaxResults+1)-1:0]  res_cnt_o
);

  state_t                    st;
  result_t [MaxPlanned-1:0]  plan;
  logic [1:0]                plan_cnt;
  logic                      pfail;
  logic                      header_only;
  logic                      start_req;
  logic [7:0]                start_s;
  logic                      start_hd;
  logic [7:0]                stat;
  logic                      stat_hd;
  msg_info_t                 dinfo;
  msg_info_t                 sinfo;
  logic [EventCountBits-1:0] room;
  logic [1:0]                allowed;
  result_t [MaxResults-1:0]  res;
  result_t                   verdict;

  assign dinfo = msg_info(state_i.msg[0]);

  always_comb begin
    st          = state_i;
    plan        = '0;
    plan_cnt    = 2'd0;
    pfail       = 1'b0;
    header_only = 1'b0;
    start_req   = 1'b0;
    start_s     = data_byte_i;
    start_hd    = 1'b0;
    stat        = data_byte_i;
    stat_hd     = 1'b0;

    if (!state_i.failed) begin
      unique case (state_i.phase)
        PhHeader: begin
          header_only = 1'b1;
          if ((data_byte_i & HeaderMask) != HeaderValue) pfail = 1'b1;
          else st.phase = PhTop;
        end
        PhTop: begin
          if (state_i.sysex_on && !data_byte_i[7]) begin
            if (state_i.fill == 2'd3) begin
              pfail = 1'b1;
            end else begin
              st.chunk[state_i.fill] = data_byte_i;
              st.fill = state_i.fill + 2'd1;
              if (state_i.fill == 2'd2) begin
                plan[0]  = mk_event(CinSysexCont, state_i.chunk[0], state_i.chunk[1],
                                    data_byte_i);
                plan_cnt = 2'd1;
                st.fill  = 2'd0;
              end
            end
          end else if (data_byte_i[7]) begin
            st.phase = PhStamped;
          end else if (state_i.stamp_needed || state_i.run_status == 8'd0) begin
            pfail = 1'b1;
          end else begin
            start_req = 1'b1;
            start_s   = state_i.run_status;
            start_hd  = 1'b1;
          end
        end
        PhStamped: begin
          if (!data_byte_i[7]) begin
            stat    = state_i.run_status;
            stat_hd = 1'b1;
          end
          if (!data_byte_i[7] && state_i.run_status == 8'd0) begin
            pfail = 1'b1;
          end else if (state_i.sysex_on) begin
            if (stat == StatusSysexEnd) begin
              case (state_i.fill)
                2'd0: begin
                  plan[0]  = mk_event(CinSysexEnd1, StatusSysexEnd, 8'd0, 8'd0);
                  plan_cnt = 2'd1;
                end
                2'd1: begin
                  plan[0]  = mk_event(CinSysexEnd2, state_i.chunk[0], StatusSysexEnd, 8'd0);
                  plan_cnt = 2'd1;
                end
                2'd2: begin
                  plan[0]  = mk_event(CinSysexEnd3, state_i.chunk[0], state_i.chunk[1],
                                      StatusSysexEnd);
                  plan_cnt = 2'd1;
                end
                default: pfail = 1'b1;
              endcase
              st.sysex_on     = 1'b0;
              st.fill         = 2'd0;
              st.stamp_needed = 1'b1;
              st.phase        = PhTop;
            end else if (stat < StatusRealtimeMin) begin
              pfail = 1'b1;
            end else begin
              plan[0]  = mk_event(CinSingleByte, state_i.chunk[0], 8'd0, 8'd0);
              plan[1]  = mk_event(CinSingleByte, state_i.chunk[1], 8'd0, 8'd0);
              plan_cnt = (state_i.fill == 2'd3) ? 2'd2 : state_i.fill;
              st.fill  = 2'd0;
              start_req = 1'b1;
              start_s   = stat;
              start_hd  = stat_hd;
            end
          end else if (stat == StatusSysexStart) begin
            st.sysex_on     = 1'b1;
            st.chunk[0]     = StatusSysexStart;
            st.fill         = 2'd1;
            st.stamp_needed = 1'b1;
            st.phase        = PhTop;
          end else begin
            start_req = 1'b1;
            start_s   = stat;
            start_hd  = stat_hd;
          end
        end
        PhData: begin
          if (data_byte_i[7]) begin
            pfail = 1'b1;
          end else if (state_i.data_left == 2'd2) begin
            st.msg[1]    = data_byte_i;
            st.data_left = 2'd1;
          end else begin
            st.data_left = 2'd0;
            st.phase     = PhTop;
            if (dinfo.len == 2'd3) begin
              plan[0] = mk_event(dinfo.cin, state_i.msg[0], state_i.msg[1], data_byte_i);
            end else begin
              plan[0] = mk_event(dinfo.cin, state_i.msg[0], data_byte_i, 8'd0);
            end
            plan_cnt = 2'd1;
          end
        end
        default: pfail = 1'b1;
      endcase
    end

    sinfo = msg_info(start_s);
    if (start_req) begin
      if (start_s[7:4] != StatusSystemNib) begin
        st.run_status   = start_s;
        st.stamp_needed = 1'b0;
      end else begin
        st.stamp_needed = 1'b1;
      end
      if (sinfo.len == 2'd0) begin
        pfail = 1'b1;
      end else begin
        st.phase = PhTop;
        if (sinfo.len == 2'd1) begin
          plan[plan_cnt] = mk_event(sinfo.cin, start_s, 8'd0, 8'd0);
          plan_cnt       = plan_cnt + 2'd1;
        end else begin
          st.msg[0] = start_s;
          if (start_hd) begin
            if (sinfo.len == 2'd2) begin
              plan[plan_cnt] = mk_event(sinfo.cin, start_s, data_byte_i, 8'd0);
              plan_cnt       = plan_cnt + 2'd1;
            end else begin
              st.msg[1]    = data_byte_i;
              st.data_left = 2'd1;
              st.phase     = PhData;
            end
          end else begin
            st.data_left = sinfo.len - 2'd1;
            st.phase     = PhData;
          end
        end
      end
    end
  end

  // Clip the planned events to the packet's remaining capacity.
  assign room    = (state_i.events < max_events_i) ? max_events_i - state_i.events : '0;
  assign allowed = (room < EventCountBits'(plan_cnt)) ? room[1:0] : plan_cnt;

  always_comb begin
    state_o        = st;
    state_o.events = st.events + EventCountBits'(allowed);
    if (pfail || allowed != plan_cnt) begin
      state_o.failed   = 1'b1;
      state_o.sysex_on = 1'b0;
      state_o.fill     = 2'd0;
    end

    res = '0;
    for (int i = 0; i < MaxPlanned; i++) begin
      if (2'(i) < allowed) res[i] = plan[i];
    end

    verdict   = '0;
    res_cnt_o = {1'b0, allowed};
    if (last_of_packet_i) begin
      if (!state_o.failed && (header_only || state_o.phase == PhStamped ||
                              state_o.phase == PhData)) begin
        state_o.failed   = 1'b1;
        state_o.sysex_on = 1'b0;
        state_o.fill     = 2'd0;
      end
      if (state_o.failed) begin
        verdict.kind = KindReject;
      end else begin
        verdict.kind  = KindAccept;
        verdict.count = state_o.events;
      end
      res[allowed] = verdict;
      res_cnt_o    = {1'b0, allowed} + 3'd1;

      state_o.phase        = PhHeader;
      state_o.run_status   = 8'd0;
      state_o.stamp_needed = 1'b1;
      state_o.data_left    = 2'd0;
      state_o.events       = '0;
      state_o.failed       = 1'b0;
    end
    res_o = res;
  end

endmodule

[rtl/bmd_result_buf.sv]
// Result register: holds the words of one byte and hands them out one per cycle while the output is ready.
module bmd_result_buf import bmd_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  result_t [MaxResults-1:0]        res_i,
  input  logic [$clog2(MaxResults+1)-1:0] res_cnt_i,
  output logic                            load_ready_o,
  bmd_out_if.source                       out_o
);

  localparam int unsigned IdxBits = $clog2(MaxResults);
  localparam int unsigned CntBits = $clog2(MaxResults + 1);

  result_t [MaxResults-1:0] res_q;
  logic [CntBits-1:0]       cnt_q;
  logic [IdxBits-1:0]       idx_q;
  logic                     is_last;
  logic                     fire;
  result_t                  cur;

  assign cur          = res_q[idx_q];
  assign is_last      = (CntBits'(idx_q) + CntBits'(1)) == cnt_q;
  assign fire         = out_o.valid && out_o.ready;
  assign load_ready_o = (cnt_q == '0) || (fire && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i && load_ready_o) begin
      cnt_q <= res_cnt_i;
      idx_q <= '0;
    end else if (fire) begin
      if (is_last) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + IdxBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = cnt_q != '0;
  assign out_o.kind        = cur.kind;
  assign out_o.code_index  = cur.cin;
  assign out_o.midi_first  = cur.first;
  assign out_o.midi_second = cur.second;
  assign out_o.midi_third  = cur.third;
  assign out_o.event_count = cur.count;
  assign out_o.last        = is_last;

endmodule

[rtl/ble_midi_to_usb_midi_decoder.sv]
// Top level of the BLE-MIDI to USB-MIDI event decoder.
// Packet bytes enter through in_i, one word per byte, last_of_packet on the final byte.
// Each accepted byte is registered, decoded combinationally against the parser state and
// its results (zero to four words: USB-MIDI events, then the accept or reject verdict
// on the packet's last byte) are loaded into the result register. The single result
// port sets the rate: one byte per cycle while each byte yields at most one word and
// the output is ready; a byte with more words, up to four for a realtime byte that
// flushes a partial SysEx chunk at the end of a packet, holds off the next byte until
// its last word has left. Events go out before the packet is judged; drop all
// events of a packet that ends with a reject word. Write max_events through
// cfg_we_i/cfg_wdata_i only while the decoder is idle; it resets to 255.
module ble_midi_to_usb_midi_decoder import bmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bmd_in_if.sink                    in_i,
  bmd_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [EventCountBits-1:0] cfg_wdata_i
);

  localparam int unsigned CntBits = $clog2(MaxResults + 1);

  logic                      in_valid_q;
  logic [7:0]                byte_q;
  logic                      last_q;
  logic [EventCountBits-1:0] max_events_q;
  state_t                    state_q;
  state_t                    state_d;
  result_t [MaxResults-1:0]  res;
  logic [CntBits-1:0]        res_cnt;
  logic                      load_ready;
  logic                      commit;

  assign commit     = in_valid_q && load_ready;
  assign in_i.ready = !in_valid_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      max_events_q <= EventCountBits'(255);
      state_q      <= StateReset;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (cfg_we_i) max_events_q <= cfg_wdata_i;
      if (commit) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_of_packet;
    end
  end

  bmd_parse u_parse (
    .state_i          (state_q),
    .data_byte_i      (byte_q),
    .last_of_packet_i (last_q),
    .max_events_i     (max_events_q),
    .state_o          (state_d),
    .res_o            (res),
    .res_cnt_o        (res_cnt)
  );

  bmd_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (commit),
    .res_i        (res),
    .res_cnt_i    (res_cnt),
    .load_ready_o (load_ready),
    .out_o        (out_o)
  );

endmodule
